// ===== sv/sorted_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH

// Check that a property holds at every clock edge outside reset.
`define SPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define SPQ_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define SPQ_ASSERT(label, clk, rst, prop, msg)
`define SPQ_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, operation and status codes, and controller command type.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH     = 16;
   localparam int TAG_WIDTH = 32;
   localparam int COUNT_W   = $clog2(DEPTH + 1);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic exec;    // apply the accepted transaction this cycle
      logic op;      // operation of that transaction
   } cmd_type;

endpackage

// ===== sv/spq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [31:0]        data_tag;
   logic signed [15:0] priority_req;

   modport source (output valid, output op, output data_tag, output priority_req,
                   input ready);
   modport sink   (input valid, input op, input data_tag, input priority_req,
                   output ready);
endinterface

interface spq_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        out_tag;
   logic signed [15:0] out_priority;
   logic [1:0]         status;
   logic [4:0]         entry_count;

   modport source (output valid, output out_tag, output out_priority,
                   output status, output entry_count, input ready);
   modport sink   (input valid, input out_tag, input out_priority,
                   input status, input entry_count, output ready);
endinterface

// ===== sv/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of tagged entries kept in ascending signed priority order.
// ----------------------------------------------------------------------------
// Each request transaction is an insert or a remove, and each one yields exactly
// one response transaction in the cycle after it is accepted. A new request is
// taken every cycle while rsp.ready is high: the response register frees up in
// the same cycle the waiting response is taken, so throughput is one transaction
// per clock and is set by the update of the shift-and-compare entry cells. Each
// cell compares its priority with the incoming one; an insert lands behind every
// entry of lower or equal priority (ties leave in arrival order) and the cells
// behind it shift down one place, while a remove shifts all cells up one place.
// Insert when full reports status full, remove when empty reports status empty,
// and neither changes the queue. Only the fill count and controller state are
// cleared by reset; the block is ready from the first cycle with no clearing pass.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req,
   spq_rsp_if.source  rsp
);

   spq_pkg::cmd_type cmd;

   // Hold the response register state and decide when to accept.
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.op),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   // Advance the entry cells and capture the response on each execute.
   spq_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .data_tag     (req.data_tag),
      .priority_req (req.priority_req),
      .out_tag      (rsp.out_tag),
      .out_priority (rsp.out_priority),
      .status       (rsp.status),
      .entry_count  (rsp.entry_count)
   );

   // A full report always comes with a full queue.
   `SPQ_ASSERT(a_full_count, clock, reset, (rsp.valid && rsp.status == spq_pkg::STATUS_FULL) |-> (rsp.entry_count == 5'(spq_pkg::DEPTH)), "full status with partial count")
   // An empty report always comes with an empty queue.
   `SPQ_ASSERT(a_empty_count, clock, reset, (rsp.valid && rsp.status == spq_pkg::STATUS_EMPTY) |-> (rsp.entry_count == 5'd0), "empty status with nonzero count")
   // Never overwrite a response that is still waiting.
   `SPQ_ASSERT_NEVER(a_no_overwrite, clock, reset, req.valid && req.ready && rsp.valid && !rsp.ready, "response overwritten")
   // Every accepted transaction shows its response on the next cycle.
   `SPQ_ASSERT(a_rsp_follows, clock, reset, (req.valid && req.ready) |=> rsp.valid, "response missing after accept")

endmodule

// ===== sv/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Tracks the response register and issues execute commands.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_op,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::cmd_type cmd
);

   typedef enum logic {
      S_EMPTY,
      S_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // Take a new transaction when no result waits or the waiting one leaves now.
   assign req_ready = (state_ff == S_EMPTY) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_HOLD);

   assign cmd.exec = accept;
   assign cmd.op   = req_op;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_EMPTY: begin
            if (accept) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (rsp_ready && !accept) state_in = S_EMPTY;
         end
         default: state_in = S_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/spq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Shift-and-compare entry cells, fill count and response register.
// ----------------------------------------------------------------------------
module spq_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_pkg::cmd_type         cmd,
   input  logic [31:0]              data_tag,
   input  logic signed [15:0]       priority_req,
   output logic [31:0]              out_tag,
   output logic signed [15:0]       out_priority,
   output logic [1:0]               status,
   output logic [4:0]               entry_count
);

   localparam int DEPTH = spq_pkg::DEPTH;
   localparam int TW    = spq_pkg::TAG_WIDTH;
   localparam int CW    = spq_pkg::COUNT_W;

   logic [TW-1:0]        tag_ff  [DEPTH];
   logic [TW-1:0]        tag_in  [DEPTH];
   logic signed [15:0]   prio_ff [DEPTH];
   logic signed [15:0]   prio_in [DEPTH];
   logic [CW-1:0]        count_ff, count_in;
   logic [TW-1:0]        otag_ff, otag_in;
   logic signed [15:0]   oprio_ff, oprio_in;
   spq_pkg::status_type  status_ff, status_in;

   logic [DEPTH-1:0]     le;
   logic [TW-1:0]        new_tag;
   logic                 full, empty, do_ins, do_rem;

   assign new_tag = TW'(data_tag);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_ins  = cmd.exec && (cmd.op == spq_pkg::OP_INSERT) && !full;
   assign do_rem  = cmd.exec && (cmd.op == spq_pkg::OP_REMOVE) && !empty;

   // Flag each stored cell that sorts ahead of the incoming entry.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le[i] = (CW'(i) < count_ff) && (prio_ff[i] <= priority_req);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         tag_in[i]  = tag_ff[i];
         prio_in[i] = prio_ff[i];
      end
      if (do_ins) begin
         if (!le[0]) begin
            tag_in[0]  = new_tag;
            prio_in[0] = priority_req;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (!le[i]) begin
               if (le[i-1]) begin
                  tag_in[i]  = new_tag;
                  prio_in[i] = priority_req;
               end else begin
                  tag_in[i]  = tag_ff[i-1];
                  prio_in[i] = prio_ff[i-1];
               end
            end
         end
      end else if (do_rem) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            tag_in[i]  = tag_ff[i+1];
            prio_in[i] = prio_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      otag_in   = otag_ff;
      oprio_in  = oprio_ff;
      status_in = status_ff;
      if (cmd.exec) begin
         otag_in   = '0;
         oprio_in  = '0;
         status_in = spq_pkg::STATUS_OK;
         if (cmd.op == spq_pkg::OP_INSERT) begin
            if (full) status_in = spq_pkg::STATUS_FULL;
            else      count_in  = count_ff + CW'(1);
         end else begin
            if (empty) begin
               status_in = spq_pkg::STATUS_EMPTY;
            end else begin
               otag_in  = tag_ff[0];
               oprio_in = prio_ff[0];
               count_in = count_ff - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         tag_ff[i]  <= tag_in[i];
         prio_ff[i] <= prio_in[i];
      end
      otag_ff   <= otag_in;
      oprio_ff  <= oprio_in;
      status_ff <= status_in;
   end

   assign out_tag      = 32'(otag_ff);
   assign out_priority = oprio_ff;
   assign status       = status_ff;
   assign entry_count  = 5'(count_ff);

endmodule
